@@ hdl/iagr_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU resampler package
// Shared types and constants for the accel-to-gyro resampler.
// ----------------------------------------------------------------------------
package iagr_pkg;

   localparam int TIME_W = 63;
   localparam int AXIS_W = 16;
   localparam int OUT_W  = 24;

   // Sample kinds carried in the mode field.
   localparam logic MODE_ACCEL = 1'b0;
   localparam logic MODE_GYRO  = 1'b1;

   // Register indexes on the configuration port.
   localparam logic CSR_GYRO_SCALE  = 1'b0;
   localparam logic CSR_ACCEL_SCALE = 1'b1;

   localparam logic [31:0] GYRO_SCALE_RST  = 32'd1143818;
   localparam logic [31:0] ACCEL_SCALE_RST = 32'd5141510;

   typedef struct packed {
      logic                     mode;
      logic [TIME_W-1:0]        sample_time;
      logic signed [AXIS_W-1:0] axis_x;
      logic signed [AXIS_W-1:0] axis_y;
      logic signed [AXIS_W-1:0] axis_z;
   } req_payload_type;

   typedef struct packed {
      logic [TIME_W-1:0]       pair_time;
      logic signed [OUT_W-1:0] rate_x;
      logic signed [OUT_W-1:0] rate_y;
      logic signed [OUT_W-1:0] rate_z;
      logic signed [OUT_W-1:0] accel_x;
      logic signed [OUT_W-1:0] accel_y;
      logic signed [OUT_W-1:0] accel_z;
      logic                    lost_flag;
      logic                    last_of_run;
   } rsp_payload_type;

   // One queued gyro sample.
   typedef struct packed {
      logic [TIME_W-1:0]        sample_time;
      logic signed [AXIS_W-1:0] axis_x;
      logic signed [AXIS_W-1:0] axis_y;
      logic signed [AXIS_W-1:0] axis_z;
   } queue_entry_type;

   // Rounded magnitude to a saturated signed 24-bit value.
   function automatic logic [OUT_W-1:0] sat_out(input logic [63:0] mag, input logic neg);
      logic [63:0] lim;
      begin
         if (neg) begin
            lim = (mag > 64'd8388608) ? 64'd8388608 : mag;
            sat_out = ~lim[OUT_W-1:0] + 24'd1;
         end else begin
            lim = (mag > 64'd8388607) ? 64'd8388607 : mag;
            sat_out = lim[OUT_W-1:0];
         end
      end
   endfunction

endpackage

@@ hdl/imu_accel_to_gyro_resampler_core.sv @@
// ----------------------------------------------------------------------------
// IMU accel-to-gyro resampler
// Queues gyro samples and releases them on the next accel sample, each paired
// with a linearly interpolated accel vector, both scaled to Q.16 SI units.
// ----------------------------------------------------------------------------
// Usage:
// A merged, time-ordered stream of samples enters on the req_ channel. A gyro
// request is absorbed while idle: it is queued, dropped or ignored. An accel
// request with queued gyros starts a release, and req_ready stays low until
// every released result has been taken on the rsp_ channel.
// Each released gyro passes through a queue read, a setup step, the restoring
// alpha divider for 16 quotient bits when alpha is not clamped, and nine passes
// of the one shared 32x32 multiplier, each a multiply and a post step, then a
// hand-over. The divider and the shared multiplier set the time per gyro.
// A stalled receiver holds the block in its output state; the result
// register keeps its value until rsp_ready is seen.
// Reset (synchronous) empties the queue, clears the history and restores the
// scale registers. The queue storage itself is not cleared.
// Configuration writes are always accepted and must only be issued while idle.
// ----------------------------------------------------------------------------
module imu_accel_to_gyro_resampler_core
   import iagr_pkg::*;
#(
   parameter int PENDING_DEPTH = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [31:0]     csr_data
);

   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int QW = $bits(queue_entry_type);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_POST  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // Multiplier passes.
   localparam logic [1:0] PH_INTERP = 2'd0;
   localparam logic [1:0] PH_ACCEL  = 2'd1;
   localparam logic [1:0] PH_GYRO   = 2'd2;

   logic [2:0]               state_ff, state_in;
   logic [31:0]              gyro_scale_ff, gyro_scale_in;
   logic [31:0]              accel_scale_ff, accel_scale_in;
   logic [TIME_W-1:0]        prev_t_ff, prev_t_in;
   logic signed [AXIS_W-1:0] prev_v_ff [3];
   logic signed [AXIS_W-1:0] prev_v_in [3];
   logic                     accel_seen_ff, accel_seen_in;
   logic [TIME_W-1:0]        prev_g_ff, prev_g_in;
   logic                     gyro_seen_ff, gyro_seen_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     overflow_ff, overflow_in;
   logic [TIME_W-1:0]        new_t_ff, new_t_in;
   logic signed [AXIS_W-1:0] new_v_ff [3];
   logic signed [AXIS_W-1:0] new_v_in [3];
   logic [63:0]              iv_ff, iv_in;
   logic                     iv_zero_ff, iv_zero_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [63:0]              rem_ff, rem_in;
   logic [15:0]              alpha_ff, alpha_in;
   logic [3:0]               bit_cnt_ff, bit_cnt_in;
   logic [1:0]               phase_ff, phase_in;
   logic [1:0]               axis_ff, axis_in;
   logic [63:0]              prod_ff, prod_in;
   logic signed [32:0]       interp_ff [3];
   logic signed [32:0]       interp_in [3];
   logic [OUT_W-1:0]         acc_out_ff [3];
   logic [OUT_W-1:0]         acc_out_in [3];
   logic [OUT_W-1:0]         rate_out_ff [3];
   logic [OUT_W-1:0]         rate_out_in [3];
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_ff, rsp_in;

   logic                     ram_we;
   queue_entry_type          ram_wdata;
   queue_entry_type          ram_rdata;
   logic [QW-1:0]            ram_rbits;

   logic signed [AXIS_W-1:0] raw_v [3];
   logic signed [AXIS_W:0]   diff;
   logic [AXIS_W:0]          diff_mag;
   logic signed [32:0]       cur_interp;
   logic [31:0]              interp_mag;
   logic [AXIS_W-1:0]        raw_mag;
   logic [31:0]              op_a, op_b;

   // Gyro queue storage.
   iagr_ram #(
      .WIDTH (QW),
      .DEPTH (PENDING_DEPTH),
      .AW    (AW)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rbits)
   );

   assign ram_rdata = queue_entry_type'(ram_rbits);
   assign ram_wdata = '{sample_time: req_data.sample_time, axis_x: req_data.axis_x,
                        axis_y: req_data.axis_y, axis_z: req_data.axis_z};
   assign raw_v[0] = ram_rdata.axis_x;
   assign raw_v[1] = ram_rdata.axis_y;
   assign raw_v[2] = ram_rdata.axis_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      diff       = {new_v_ff[axis_ff][AXIS_W-1], new_v_ff[axis_ff]}
                 - {prev_v_ff[axis_ff][AXIS_W-1], prev_v_ff[axis_ff]};
      diff_mag   = diff[AXIS_W] ? (~diff + 1'b1) : diff;
      cur_interp = interp_ff[axis_ff];
      interp_mag = cur_interp[32] ? 32'(-cur_interp) : cur_interp[31:0];
      raw_mag    = raw_v[axis_ff][AXIS_W-1] ? AXIS_W'(-raw_v[axis_ff]) : raw_v[axis_ff];
      case (phase_ff)
         PH_INTERP: begin
            op_a = {15'd0, diff_mag};
            op_b = {16'd0, alpha_ff};
         end
         PH_ACCEL: begin
            op_a = interp_mag;
            op_b = accel_scale_ff;
         end
         default: begin
            op_a = {16'd0, raw_mag};
            op_b = gyro_scale_ff;
         end
      endcase
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      logic [63:0]        r2;
      logic               qbit;
      logic signed [32:0] base;
      logic [OUT_W-1:0]   gyro_res;
      logic [TIME_W-1:0]  g;

      state_in       = state_ff;
      gyro_scale_in  = gyro_scale_ff;
      accel_scale_in = accel_scale_ff;
      prev_t_in      = prev_t_ff;
      prev_v_in      = prev_v_ff;
      accel_seen_in  = accel_seen_ff;
      prev_g_in      = prev_g_ff;
      gyro_seen_in   = gyro_seen_ff;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      new_t_in       = new_t_ff;
      new_v_in       = new_v_ff;
      iv_in          = iv_ff;
      iv_zero_in     = iv_zero_ff;
      idx_in         = idx_ff;
      rem_in         = rem_ff;
      alpha_in       = alpha_ff;
      bit_cnt_in     = bit_cnt_ff;
      phase_in       = phase_ff;
      axis_in        = axis_ff;
      prod_in        = prod_ff;
      interp_in      = interp_ff;
      acc_out_in     = acc_out_ff;
      rate_out_in    = rate_out_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      ram_we         = 1'b0;
      r2             = '0;
      qbit           = 1'b0;
      base           = '0;
      gyro_res       = '0;
      g              = ram_rdata.sample_time;

      // Register writes.
      if (csr_valid) begin
         if (csr_index == CSR_GYRO_SCALE) begin
            gyro_scale_in = csr_data;
         end else begin
            accel_scale_in = csr_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == MODE_GYRO) begin
                  if (!(gyro_seen_ff && req_data.sample_time == prev_g_ff)) begin
                     prev_g_in    = req_data.sample_time;
                     gyro_seen_in = 1'b1;
                     if (accel_seen_ff) begin
                        if (count_ff >= CW'(PENDING_DEPTH)) begin
                           overflow_in = 1'b1;
                        end else begin
                           ram_we   = 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
               end else if (!(accel_seen_ff && req_data.sample_time == prev_t_ff)) begin
                  if (count_ff == '0) begin
                     prev_t_in     = req_data.sample_time;
                     prev_v_in[0]  = req_data.axis_x;
                     prev_v_in[1]  = req_data.axis_y;
                     prev_v_in[2]  = req_data.axis_z;
                     accel_seen_in = 1'b1;
                  end else begin
                     new_t_in    = req_data.sample_time;
                     new_v_in[0] = req_data.axis_x;
                     new_v_in[1] = req_data.axis_y;
                     new_v_in[2] = req_data.axis_z;
                     iv_in       = {1'b0, req_data.sample_time - prev_t_ff};
                     iv_zero_in  = (req_data.sample_time <= prev_t_ff);
                     idx_in      = '0;
                     state_in    = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            phase_in = PH_INTERP;
            axis_in  = 2'd0;
            if (iv_zero_ff || g <= prev_t_ff) begin
               alpha_in = 16'h0000;
               state_in = ST_MUL;
            end else if (g >= new_t_ff) begin
               alpha_in = 16'hFFFF;
               state_in = ST_MUL;
            end else begin
               rem_in     = {1'b0, g - prev_t_ff};
               alpha_in   = 16'h0000;
               bit_cnt_in = 4'd0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            // One restoring quotient bit per cycle.
            r2 = {rem_ff[62:0], 1'b0};
            if (r2 >= iv_ff) begin
               r2   = r2 - iv_ff;
               qbit = 1'b1;
            end
            rem_in     = r2;
            alpha_in   = {alpha_ff[14:0], qbit};
            bit_cnt_in = bit_cnt_ff + 4'd1;
            if (bit_cnt_ff == 4'd15) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = op_a * op_b;
            state_in = ST_POST;
         end
         ST_POST: begin
            case (phase_ff)
               PH_INTERP: begin
                  base = {prev_v_ff[axis_ff][AXIS_W-1], prev_v_ff[axis_ff], 16'd0};
                  interp_in[axis_ff] = diff[AXIS_W] ? (base - $signed({1'b0, prod_ff[31:0]}))
                                                    : (base + $signed({1'b0, prod_ff[31:0]}));
               end
               PH_ACCEL: begin
                  acc_out_in[axis_ff] = sat_out((prod_ff + 64'h8000_0000) >> 32,
                                                cur_interp[32]);
               end
               default: begin
                  gyro_res = sat_out((prod_ff + 64'h8000) >> 16, raw_v[axis_ff][AXIS_W-1]);
                  rate_out_in[axis_ff] = gyro_res;
               end
            endcase
            state_in = ST_MUL;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               phase_in = phase_ff + 2'd1;
               if (phase_ff == PH_GYRO) begin
                  // All nine passes done: load the result register.
                  rsp_in.pair_time   = g;
                  rsp_in.rate_x      = rate_out_ff[0];
                  rsp_in.rate_y      = rate_out_ff[1];
                  rsp_in.rate_z      = gyro_res;
                  rsp_in.accel_x     = acc_out_ff[0];
                  rsp_in.accel_y     = acc_out_ff[1];
                  rsp_in.accel_z     = acc_out_ff[2];
                  rsp_in.lost_flag   = (idx_ff == '0) && overflow_ff;
                  rsp_in.last_of_run = (idx_ff + 1'b1 == count_ff);
                  if (idx_ff == '0) begin
                     overflow_in = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (idx_ff + 1'b1 == count_ff) begin
                  count_in      = '0;
                  prev_t_in     = new_t_ff;
                  prev_v_in     = new_v_ff;
                  accel_seen_in = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gyro_scale_ff  <= GYRO_SCALE_RST;
         accel_scale_ff <= ACCEL_SCALE_RST;
         prev_t_ff      <= '0;
         prev_v_ff      <= '{default: '0};
         accel_seen_ff  <= 1'b0;
         prev_g_ff      <= '0;
         gyro_seen_ff   <= 1'b0;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gyro_scale_ff  <= gyro_scale_in;
         accel_scale_ff <= accel_scale_in;
         prev_t_ff      <= prev_t_in;
         prev_v_ff      <= prev_v_in;
         accel_seen_ff  <= accel_seen_in;
         prev_g_ff      <= prev_g_in;
         gyro_seen_ff   <= gyro_seen_in;
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      new_t_ff    <= new_t_in;
      new_v_ff    <= new_v_in;
      iv_ff       <= iv_in;
      iv_zero_ff  <= iv_zero_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      alpha_ff    <= alpha_in;
      bit_cnt_ff  <= bit_cnt_in;
      phase_ff    <= phase_in;
      axis_ff     <= axis_in;
      prod_ff     <= prod_in;
      interp_ff   <= interp_in;
      acc_out_ff  <= acc_out_in;
      rate_out_ff <= rate_out_in;
      rsp_ff      <= rsp_in;
   end

   // A result is only offered from the output state.
   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT)
      else $error("result valid outside output state");

   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PENDING_DEPTH))
      else $error("queue count beyond depth");

   // A release only runs with queued entries, and the index stays inside them.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> idx_ff < count_ff)
      else $error("release index outside queued entries");

   // A taken last result returns the block to idle with an empty queue.
   a_release_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && rsp_ff.last_of_run |=> state_ff == ST_IDLE && count_ff == '0)
      else $error("release did not end cleanly");

endmodule

@@ hdl/iagr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module iagr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/imu_accel_to_gyro_resampler_core_tb.sv @@
// ----------------------------------------------------------------------------
// IMU resampler testbench
// Drives merged accel/gyro sample streams into the resampler, predicts every
// released gyro/accel pair in a behavioral model and compares the results
// field by field, under random idling on both channels and one long stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_accel_to_gyro_resampler_core_tb;
   import iagr_pkg::*;

   localparam int DEPTH      = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic            csr_index;
   logic [31:0]     csr_data;

   imu_accel_to_gyro_resampler_core #(.PENDING_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Clock generation.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Predictor state.
   logic [31:0]        mdl_gyro_scale;
   logic [31:0]        mdl_accel_scale;
   logic [TIME_W-1:0]  mdl_accel_time;
   logic signed [15:0] mdl_accel_vec [3];
   logic               mdl_accel_seen;
   logic [TIME_W-1:0]  mdl_gyro_time;
   logic               mdl_gyro_seen;
   logic [TIME_W-1:0]  mdl_q_time [DEPTH];
   logic signed [15:0] mdl_q_rate [DEPTH][3];
   int                 mdl_q_count;
   logic               mdl_overflow;

   req_payload_type pending_requests [$];
   rsp_payload_type expected_pairs [$];
   int  mismatch_count;
   int  pairs_checked;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_cycles;
   int  hold_len;
   logic [TIME_W-1:0] stream_time;

   // Round-half-away scaling of a signed value, saturated to 24 bits.
   function automatic logic [OUT_W-1:0] scale_round_sat(input longint v,
         input logic [31:0] s, input int sh);
      logic [127:0] mag;
      logic [127:0] r;
      logic [OUT_W-1:0] res;
      mag = (v < 0) ? 128'(-v) : 128'(v);
      r = (mag * 128'(s) + (128'd1 << (sh - 1))) >> sh;
      if (v < 0) begin
         if (r > 128'd8388608) r = 128'd8388608;
         res = -r[OUT_W-1:0];
      end else begin
         if (r > 128'd8388607) r = 128'd8388607;
         res = r[OUT_W-1:0];
      end
      return res;
   endfunction

   // Q0.16 interpolation fraction by restoring division.
   function automatic logic [15:0] interp_fraction(input logic [TIME_W-1:0] g,
         input logic [TIME_W-1:0] p, input logic [TIME_W-1:0] t);
      logic [64:0] iv;
      logic [64:0] rem;
      logic [15:0] q;
      q = '0;
      if (t <= p || g <= p) return 16'd0;
      if (g >= t) return 16'hFFFF;
      iv = 65'(t - p);
      rem = 65'(g - p);
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= iv) begin
            rem = rem - iv;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // Apply one accepted sample to the predictor and queue released pairs.
   task automatic predict_pairs(input req_payload_type it);
      logic signed [15:0] v [3];
      rsp_payload_type pr;
      logic [15:0] a;
      longint interp;
      v[0] = it.axis_x;
      v[1] = it.axis_y;
      v[2] = it.axis_z;
      if (it.mode == MODE_GYRO) begin
         if (mdl_gyro_seen && it.sample_time == mdl_gyro_time) return;
         mdl_gyro_time = it.sample_time;
         mdl_gyro_seen = 1'b1;
         if (!mdl_accel_seen) return;
         if (mdl_q_count >= DEPTH) begin
            mdl_overflow = 1'b1;
            return;
         end
         mdl_q_time[mdl_q_count] = it.sample_time;
         for (int k = 0; k < 3; k++) mdl_q_rate[mdl_q_count][k] = v[k];
         mdl_q_count++;
         return;
      end
      if (mdl_accel_seen && it.sample_time == mdl_accel_time) return;
      for (int i = 0; i < mdl_q_count; i++) begin
         a = interp_fraction(mdl_q_time[i], mdl_accel_time, it.sample_time);
         pr.pair_time = mdl_q_time[i];
         pr.rate_x = scale_round_sat(longint'(mdl_q_rate[i][0]), mdl_gyro_scale, 16);
         pr.rate_y = scale_round_sat(longint'(mdl_q_rate[i][1]), mdl_gyro_scale, 16);
         pr.rate_z = scale_round_sat(longint'(mdl_q_rate[i][2]), mdl_gyro_scale, 16);
         interp = longint'(mdl_accel_vec[0]) * 65536
                  + longint'(a) * (longint'(v[0]) - longint'(mdl_accel_vec[0]));
         pr.accel_x = scale_round_sat(interp, mdl_accel_scale, 32);
         interp = longint'(mdl_accel_vec[1]) * 65536
                  + longint'(a) * (longint'(v[1]) - longint'(mdl_accel_vec[1]));
         pr.accel_y = scale_round_sat(interp, mdl_accel_scale, 32);
         interp = longint'(mdl_accel_vec[2]) * 65536
                  + longint'(a) * (longint'(v[2]) - longint'(mdl_accel_vec[2]));
         pr.accel_z = scale_round_sat(interp, mdl_accel_scale, 32);
         pr.lost_flag = (i == 0) && mdl_overflow;
         pr.last_of_run = (i + 1 == mdl_q_count);
         expected_pairs.insert(expected_pairs.size(), pr);
      end
      if (mdl_q_count > 0) mdl_overflow = 1'b0;
      mdl_q_count = 0;
      mdl_accel_time = it.sample_time;
      for (int k = 0; k < 3; k++) mdl_accel_vec[k] = v[k];
      mdl_accel_seen = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
         input logic [63:0] want);
      $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what,
               got, want);
      mismatch_count++;
   endtask

   function automatic req_payload_type make_sample(input logic m,
         input logic [TIME_W-1:0] t, input logic [15:0] x, input logic [15:0] y,
         input logic [15:0] z);
      req_payload_type s;
      s.mode = m;
      s.sample_time = t;
      s.axis_x = x;
      s.axis_y = y;
      s.axis_z = z;
      return s;
   endfunction

   // Append one request to the end of the pending list.
   task automatic add_request(input req_payload_type s);
      pending_requests.insert(pending_requests.size(), s);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Well-formed run: a burst of gyros, then the closing accel.
   task automatic add_random_run();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 6);
      stream_time = stream_time + TIME_W'($urandom_range(1, 5000));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // Repeated gyro time, unless it is the first gyro of the run.
            add_request(make_sample(MODE_GYRO, stream_time,
               rand_axis(), rand_axis(), rand_axis()));
         end else begin
            stream_time = stream_time + TIME_W'($urandom_range(1, 3000));
            add_request(make_sample(MODE_GYRO, stream_time,
               rand_axis(), rand_axis(), rand_axis()));
         end
      end
      if ($urandom_range(0, 7) != 0)
         stream_time = stream_time + TIME_W'($urandom_range(1, 3000));
      add_request(make_sample(MODE_ACCEL, stream_time,
         rand_axis(), rand_axis(), rand_axis()));
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_GYRO_SCALE) mdl_gyro_scale = val;
      else mdl_accel_scale = val;
   endtask

   // Request driver; the predictor history is cleared with the block.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         mdl_accel_time = '0;
         mdl_accel_seen = 1'b0;
         mdl_gyro_time = '0;
         mdl_gyro_seen = 1'b0;
         mdl_q_count = 0;
         mdl_overflow = 1'b0;
         for (int k = 0; k < 3; k++) mdl_accel_vec[k] = '0;
      end else begin
         if (req_valid && req_ready) predict_pairs(req_data);
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
               req_data <= pending_requests[0];
               void'(pending_requests.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready: random idling plus a counted long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles < hold_len) begin
         hold_cycles <= hold_cycles + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            report_mismatch("unexpected result time", 64'(rsp_data.pair_time), 64'd0);
         end else begin
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (rsp_data.pair_time !== want.pair_time)
               report_mismatch("pair_time", 64'(rsp_data.pair_time), 64'(want.pair_time));
            if (rsp_data.rate_x !== want.rate_x)
               report_mismatch("rate_x", 64'(rsp_data.rate_x), 64'(want.rate_x));
            if (rsp_data.rate_y !== want.rate_y)
               report_mismatch("rate_y", 64'(rsp_data.rate_y), 64'(want.rate_y));
            if (rsp_data.rate_z !== want.rate_z)
               report_mismatch("rate_z", 64'(rsp_data.rate_z), 64'(want.rate_z));
            if (rsp_data.accel_x !== want.accel_x)
               report_mismatch("accel_x", 64'(rsp_data.accel_x), 64'(want.accel_x));
            if (rsp_data.accel_y !== want.accel_y)
               report_mismatch("accel_y", 64'(rsp_data.accel_y), 64'(want.accel_y));
            if (rsp_data.accel_z !== want.accel_z)
               report_mismatch("accel_z", 64'(rsp_data.accel_z), 64'(want.accel_z));
            if (rsp_data.lost_flag !== want.lost_flag)
               report_mismatch("lost_flag", 64'(rsp_data.lost_flag), 64'(want.lost_flag));
            if (rsp_data.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 64'(rsp_data.last_of_run),
                               64'(want.last_of_run));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_pairs.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stimulus sequence.
   initial begin
      logic [TIME_W-1:0] tmax;
      tmax = '1;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_GYRO_SCALE;
      csr_data = '0;
      hold_len = 0;
      send_idle_pct = 19;
      recv_idle_pct = 78;
      stream_time = '0;
      mdl_gyro_scale = GYRO_SCALE_RST;
      mdl_accel_scale = ACCEL_SCALE_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: gyro before any accel, repeats, ties, extremes, overflow.
      add_request(make_sample(MODE_GYRO, 63'd0, 16'h7FFF, 16'h8000, 16'h0));
      add_request(make_sample(MODE_GYRO, 63'd0, 16'h1, 16'h1, 16'h1));
      add_request(make_sample(MODE_ACCEL, 63'd0, 16'h8000, 16'h7FFF, 16'h0));
      add_request(make_sample(MODE_ACCEL, 63'd0, 16'h1, 16'h2, 16'h3));
      add_request(make_sample(MODE_GYRO, 63'd0, 16'h7FFF, 16'h8000, 16'hFFFF));
      add_request(make_sample(MODE_GYRO, 63'd0, 16'h0, 16'h0, 16'h0));
      add_request(make_sample(MODE_GYRO, 63'd100, 16'h8000, 16'h7FFF, 16'h1));
      add_request(make_sample(MODE_GYRO, 63'd500, 16'h1234, 16'hEDCB, 16'h5));
      add_request(make_sample(MODE_ACCEL, 63'd200, 16'h7FFF, 16'h8000, 16'h4));
      for (int i = 1; i <= 10; i++)
         add_request(make_sample(MODE_GYRO, 63'(200 + 10 * i),
            16'(i * 3001), 16'(-i * 2999), 16'(i)));
      add_request(make_sample(MODE_ACCEL, 63'd150, 16'h8000, 16'h8000,
         16'h7FFF));
      add_request(make_sample(MODE_GYRO, tmax, 16'h5555, 16'hAAAA, 16'h7FFF));
      add_request(make_sample(MODE_ACCEL, tmax, 16'hAAAA, 16'h5555, 16'h8000));
      wait_drained();

      // Extreme scales, then random runs across the idling phases.
      write_csr(CSR_GYRO_SCALE, 32'hFFFF_FFFF);
      write_csr(CSR_ACCEL_SCALE, 32'hFFFF_FFFF);
      stream_time = '0;
      add_request(make_sample(MODE_ACCEL, 63'd10, 16'h8000, 16'h7FFF,
         16'h1));
      for (int i = 0; i < 4; i++) add_request(make_sample(MODE_GYRO,
         63'(20 + i), 16'h8000, 16'h7FFF, 16'hFFFF));
      add_request(make_sample(MODE_ACCEL, 63'd40, 16'h7FFF, 16'h8000,
         16'h0));
      stream_time = 63'd40;
      for (int i = 0; i < 7; i++) add_random_run();
      wait_drained();

      write_csr(CSR_GYRO_SCALE, 32'd0);
      write_csr(CSR_ACCEL_SCALE, 32'd0);
      for (int i = 0; i < 3; i++) add_random_run();
      wait_drained();

      // Long receiver stall while the sender keeps offering gyros.
      write_csr(CSR_GYRO_SCALE, $urandom);
      write_csr(CSR_ACCEL_SCALE, $urandom);
      hold_len = 600;
      for (int i = 0; i < 2; i++) add_random_run();
      for (int i = 0; i < 6; i++) add_random_run();
      wait_drained();

      send_idle_pct = 78;
      recv_idle_pct = 19;
      write_csr(CSR_GYRO_SCALE, GYRO_SCALE_RST);
      write_csr(CSR_ACCEL_SCALE, ACCEL_SCALE_RST);
      for (int i = 0; i < 8; i++) add_random_run();
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_GYRO_SCALE, $urandom);
      write_csr(CSR_ACCEL_SCALE, $urandom);
      for (int i = 0; i < 8; i++) add_random_run();
      stream_time = tmax - 63'd100000;
      for (int i = 0; i < 2; i++) add_random_run();
      wait_drained();

      $display("Covered %0d released pairs across scale extremes, queue overflow,",
               pairs_checked);
      $display("repeated and tied timestamps, and sender/receiver stall phases.");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
